>>> hdl/temp_register_allocator_macros.svh
// Assertion macros for the temporary register allocator.
// Used by temp_register_allocator.sv; expects clk and rst_n in scope.
`ifndef TEMP_REGISTER_ALLOCATOR_MACROS_SVH
`define TEMP_REGISTER_ALLOCATOR_MACROS_SVH

// Check a same-cycle implication, skipped while in reset
`define TRA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequent is checked in the next cycle
`define TRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tra_pkg.sv
// Shared types, constants and helper functions for the temporary register allocator.
// No dependencies; imported by tra_map_table and temp_register_allocator.
package tra_pkg;

    localparam int NUM_TEMPS    = 15;
    localparam int NUM_VIRTUALS = 256;
    localparam int TEMP_W       = (NUM_TEMPS > 1) ? $clog2(NUM_TEMPS) : 1;
    localparam int VIRT_W       = $clog2(NUM_VIRTUALS);
    localparam int SNAP_W       = 16;

    typedef enum logic [3:0] {
        OP_PASS      = 4'd0,
        OP_DEFINE    = 4'd1,
        OP_FUNC_ARG  = 4'd2,
        OP_CALL      = 4'd3,
        OP_TWO_REGS  = 4'd4,
        OP_STORE     = 4'd5,
        OP_USE       = 4'd6,
        OP_KILL      = 4'd7,
        OP_NEW_FUNC  = 4'd8
    } opcode_e;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] lhs_in;
        logic signed [31:0] rhs_in;
    } tra_item_t;

    typedef struct packed {
        logic [3:0]           op_out;
        logic signed [31:0]   lhs_out;
        logic [1:0]           lhs_status;
        logic signed [31:0]   rhs_out;
        logic [1:0]           rhs_status;
        logic [NUM_TEMPS-1:0] used_mask;
    } tra_result_t;

    // Map table write request: port B is applied after port A
    typedef struct packed {
        logic              a_en;
        logic [VIRT_W-1:0] a_addr;
        logic [TEMP_W-1:0] a_data;
        logic              b_en;
        logic [VIRT_W-1:0] b_addr;
        logic [TEMP_W-1:0] b_data;
        logic              clear;
    } map_wr_t;

    typedef struct packed {
        logic              valid;
        logic [TEMP_W-1:0] entry;
    } map_look_t;

    typedef struct packed {
        logic              found;
        logic [TEMP_W-1:0] idx;
    } free_pick_t;

    // Lowest clear bit of the used bitmap
    function automatic free_pick_t lowest_free(logic [NUM_TEMPS-1:0] used);
        free_pick_t pick;
        pick.found = 1'b0;
        pick.idx   = '0;
        for (int i = NUM_TEMPS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                pick.found = 1'b1;
                pick.idx   = TEMP_W'(i);
            end
        end
        return pick;
    endfunction

    function automatic logic [NUM_TEMPS-1:0] temp_bit(logic [TEMP_W-1:0] idx);
        return NUM_TEMPS'(1) << idx;
    endfunction

    function automatic logic virt_in_range(logic signed [31:0] v);
        return (v >= 0) && (v < NUM_VIRTUALS);
    endfunction

    function automatic logic arg_in_range(logic signed [31:0] v);
        return (v >= 0) && (v < NUM_TEMPS);
    endfunction

endpackage

>>> hdl/tra_map_table.sv
// Virtual-to-physical map table: two write banks, per-entry bank select and valid bits.
// Depends on tra_pkg. Reads are issued when a word is taken and resolved from registered reads in the next cycle.
module tra_map_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [tra_pkg::VIRT_W-1:0] rd_lhs_addr,
    input  logic [tra_pkg::VIRT_W-1:0] rd_rhs_addr,
    input  tra_pkg::map_wr_t          wr,
    output tra_pkg::map_look_t        look_lhs,
    output tra_pkg::map_look_t        look_rhs
);
    import tra_pkg::*;

    logic [TEMP_W-1:0]       bank_a_mem [NUM_VIRTUALS];
    logic [TEMP_W-1:0]       bank_b_mem [NUM_VIRTUALS];
    logic [TEMP_W-1:0]       a_lhs_reg, a_rhs_reg, b_lhs_reg, b_rhs_reg;
    logic [VIRT_W-1:0]       lhs_addr_reg, rhs_addr_reg;
    map_wr_t                 fwd_reg;
    logic [NUM_VIRTUALS-1:0] valid_reg;
    logic [NUM_VIRTUALS-1:0] sel_b_reg;
    logic [TEMP_W-1:0]       a_lhs, a_rhs, b_lhs, b_rhs;
    logic                    a_only;

    // Port A counts only where port B does not hit the same entry
    assign a_only = wr.a_en && !(wr.b_en && (wr.b_addr == wr.a_addr));

    // Bank A: first write of an item, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr.a_en)
        begin
            bank_a_mem[wr.a_addr] <= wr.a_data;
        end
        if (rd_en)
        begin
            a_lhs_reg <= bank_a_mem[rd_lhs_addr];
            a_rhs_reg <= bank_a_mem[rd_rhs_addr];
        end
    end

    // Bank B: second write of an item, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr.b_en)
        begin
            bank_b_mem[wr.b_addr] <= wr.b_data;
        end
        if (rd_en)
        begin
            b_lhs_reg <= bank_b_mem[rd_lhs_addr];
            b_rhs_reg <= bank_b_mem[rd_rhs_addr];
        end
    end

    // Hold read addresses and the writes that land on the same edge as the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lhs_addr_reg <= rd_lhs_addr;
            rhs_addr_reg <= rd_rhs_addr;
            fwd_reg      <= wr;
        end
    end

    // Track which bank holds the newest value; B wins when both hit one entry
    always_ff @(posedge clk)
    begin
        if (a_only)
        begin
            sel_b_reg[wr.a_addr] <= 1'b0;
        end
        if (wr.b_en)
        begin
            sel_b_reg[wr.b_addr] <= 1'b1;
        end
    end

    // Valid bits: drop all on reset or a new function, else set on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.clear)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (a_only)
            begin
                valid_reg[wr.a_addr] <= 1'b1;
            end
            if (wr.b_en)
            begin
                valid_reg[wr.b_addr] <= 1'b1;
            end
        end
    end

    // Bypass writes that the memory read missed
    always_comb
    begin
        a_lhs = (fwd_reg.a_en && fwd_reg.a_addr == lhs_addr_reg) ? fwd_reg.a_data : a_lhs_reg;
        a_rhs = (fwd_reg.a_en && fwd_reg.a_addr == rhs_addr_reg) ? fwd_reg.a_data : a_rhs_reg;
        b_lhs = (fwd_reg.b_en && fwd_reg.b_addr == lhs_addr_reg) ? fwd_reg.b_data : b_lhs_reg;
        b_rhs = (fwd_reg.b_en && fwd_reg.b_addr == rhs_addr_reg) ? fwd_reg.b_data : b_rhs_reg;

        look_lhs.valid = valid_reg[lhs_addr_reg];
        look_lhs.entry = sel_b_reg[lhs_addr_reg] ? b_lhs : a_lhs;
        look_rhs.valid = valid_reg[rhs_addr_reg];
        look_rhs.entry = sel_b_reg[rhs_addr_reg] ? b_rhs : a_rhs;
    end

endmodule

>>> hdl/temp_register_allocator.sv
// Temporary register allocator: maps virtual registers onto physical temporaries.
// Depends on tra_pkg, tra_map_table and temp_register_allocator_macros.svh.
// Flow: a word taken into the input register moves on into the result register,
// unless the result register is still held by an unaccepted word.
// Throughput: one word per cycle unless result_ready stalls; input and result registers each hold one word.
// Per-cycle work is a lookup of both operands and two cascaded lowest-free picks over the bitmap.
// Reset (async, active low) frees all temporaries, zeroes the snapshot count, unmaps all
// virtual registers and empties both stages at once; map entries themselves are not cleared.
`include "temp_register_allocator_macros.svh"

module temp_register_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  tra_pkg::tra_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output tra_pkg::tra_result_t result
);
    import tra_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    tra_item_t             s1_item_reg;
    logic                  out_valid_reg, out_valid_next;
    tra_result_t           result_reg, result_next;
    logic [NUM_TEMPS-1:0]  used_reg, used_next, used_calc;
    logic [SNAP_W-1:0]     snap_reg, snap_next;

    logic                  item_take, s1_fire;
    logic signed [31:0]    lhs_v, rhs_v;
    logic                  lhs_rng, rhs_rng;
    map_look_t             look_lhs, look_rhs;
    map_wr_t               map_wr;

    free_pick_t            pick_l, pick_r;
    logic [1:0]            la_stat, ra_stat, lk_stat;
    logic [TEMP_W-1:0]     la_val, ra_val;
    logic                  la_write, ra_write, same_vr;
    logic [NUM_TEMPS-1:0]  used_after_l, used_base_r, used_after_r, kill_mask;
    logic                  arg_rng, arg_busy, arg_take, ro_in_map, arg_map_write;
    logic [TEMP_W-1:0]     arg_idx;

    // Handshake: advance stage 1 when the result register is free or drains
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_fire;
    assign item_take  = item_valid && item_ready;

    assign lhs_v   = s1_item_reg.lhs_in;
    assign rhs_v   = s1_item_reg.rhs_in;
    assign lhs_rng = virt_in_range(lhs_v);
    assign rhs_rng = virt_in_range(rhs_v);

    tra_map_table u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (item_take),
        .rd_lhs_addr (item.lhs_in[VIRT_W-1:0]),
        .rd_rhs_addr (item.rhs_in[VIRT_W-1:0]),
        .wr          (map_wr),
        .look_lhs    (look_lhs),
        .look_rhs    (look_rhs)
    );

    // Allocate lhs against the current bitmap
    assign pick_l = lowest_free(used_reg);
    always_comb
    begin
        la_write = 1'b0;
        la_val   = '0;
        if (!lhs_rng)
        begin
            la_stat = ST_RANGE;
        end
        else if (look_lhs.valid)
        begin
            la_stat = ST_OK;
            la_val  = look_lhs.entry;
        end
        else if (pick_l.found)
        begin
            la_stat  = ST_OK;
            la_val   = pick_l.idx;
            la_write = 1'b1;
        end
        else
        begin
            la_stat = ST_NO_FREE;
        end
    end
    assign used_after_l = used_reg | (la_write ? temp_bit(pick_l.idx) : '0);

    // Allocate rhs; for two-register ops it follows the lhs allocation
    assign used_base_r = (s1_item_reg.opcode == OP_TWO_REGS) ? used_after_l : used_reg;
    assign same_vr     = (s1_item_reg.opcode == OP_TWO_REGS) && (lhs_v == rhs_v);
    assign pick_r      = lowest_free(used_base_r);
    always_comb
    begin
        ra_write = 1'b0;
        ra_val   = '0;
        if (same_vr)
        begin
            ra_stat = la_stat;
            ra_val  = la_val;
        end
        else if (!rhs_rng)
        begin
            ra_stat = ST_RANGE;
        end
        else if (look_rhs.valid)
        begin
            ra_stat = ST_OK;
            ra_val  = look_rhs.entry;
        end
        else if (pick_r.found)
        begin
            ra_stat  = ST_OK;
            ra_val   = pick_r.idx;
            ra_write = 1'b1;
        end
        else
        begin
            ra_stat = ST_NO_FREE;
        end
    end
    assign used_after_r = used_base_r | (ra_write ? temp_bit(pick_r.idx) : '0);

    // Argument register counted down from the top temporary
    assign arg_rng       = arg_in_range(lhs_v);
    assign arg_idx       = TEMP_W'(NUM_TEMPS - 1) - lhs_v[TEMP_W-1:0];
    assign arg_busy      = arg_rng && used_after_r[arg_idx];
    assign arg_take      = arg_rng && !arg_busy;
    assign ro_in_map     = (32'(ra_val) < NUM_VIRTUALS);
    assign arg_map_write = arg_take && (ra_stat == ST_OK) && ro_in_map;

    // Plain lookup of lhs and the bit a kill releases
    always_comb
    begin
        if (!lhs_rng)
        begin
            lk_stat = ST_RANGE;
        end
        else if (!look_lhs.valid)
        begin
            lk_stat = ST_UNMAPPED;
        end
        else
        begin
            lk_stat = ST_OK;
        end
    end
    assign kill_mask = (lk_stat == ST_OK && 32'(look_lhs.entry) < NUM_TEMPS)
                       ? temp_bit(look_lhs.entry) : '0;

    // Build the result word, the bitmap update and the map writes
    always_comb
    begin
        result_next.op_out     = s1_item_reg.opcode;
        result_next.lhs_out    = lhs_v;
        result_next.lhs_status = ST_OK;
        result_next.rhs_out    = rhs_v;
        result_next.rhs_status = ST_OK;
        result_next.used_mask  = '0;
        used_calc              = used_reg;
        map_wr                 = '0;

        case (s1_item_reg.opcode)
            OP_DEFINE:
            begin
                result_next.lhs_out    = 32'(la_val);
                result_next.lhs_status = la_stat;
                used_calc              = used_after_l;
                map_wr.a_en            = la_write;
                map_wr.a_addr          = lhs_v[VIRT_W-1:0];
                map_wr.a_data          = pick_l.idx;
            end
            OP_FUNC_ARG:
            begin
                result_next.rhs_out    = 32'(ra_val);
                result_next.rhs_status = ra_stat;
                map_wr.a_en            = ra_write;
                map_wr.a_addr          = rhs_v[VIRT_W-1:0];
                map_wr.a_data          = pick_r.idx;
                if (!arg_rng)
                begin
                    result_next.lhs_out    = '0;
                    result_next.lhs_status = ST_RANGE;
                end
                else if (arg_busy)
                begin
                    result_next.lhs_out    = '0;
                    result_next.lhs_status = ST_NO_FREE;
                end
                else
                begin
                    result_next.lhs_out = 32'(arg_idx);
                end
                used_calc     = used_after_r | (arg_take ? temp_bit(arg_idx) : '0);
                map_wr.b_en   = arg_map_write;
                map_wr.b_addr = VIRT_W'(ra_val);
                map_wr.b_data = arg_idx;
            end
            OP_CALL:
            begin
                result_next.used_mask  = used_reg;
                result_next.rhs_out    = 32'(snap_reg);
                result_next.lhs_out    = 32'(la_val);
                result_next.lhs_status = la_stat;
                used_calc              = used_after_l;
                map_wr.a_en            = la_write;
                map_wr.a_addr          = lhs_v[VIRT_W-1:0];
                map_wr.a_data          = pick_l.idx;
            end
            OP_TWO_REGS:
            begin
                result_next.lhs_out    = 32'(la_val);
                result_next.lhs_status = la_stat;
                result_next.rhs_out    = 32'(ra_val);
                result_next.rhs_status = ra_stat;
                used_calc              = used_after_r;
                map_wr.a_en            = la_write;
                map_wr.a_addr          = lhs_v[VIRT_W-1:0];
                map_wr.a_data          = pick_l.idx;
                map_wr.b_en            = ra_write;
                map_wr.b_addr          = rhs_v[VIRT_W-1:0];
                map_wr.b_data          = pick_r.idx;
            end
            OP_STORE:
            begin
                result_next.lhs_out    = (lk_stat == ST_OK) ? 32'(look_lhs.entry) : '0;
                result_next.lhs_status = lk_stat;
                result_next.rhs_out    = 32'(ra_val);
                result_next.rhs_status = ra_stat;
                used_calc              = used_after_r;
                map_wr.a_en            = ra_write;
                map_wr.a_addr          = rhs_v[VIRT_W-1:0];
                map_wr.a_data          = pick_r.idx;
            end
            OP_USE:
            begin
                result_next.lhs_out    = (lk_stat == ST_OK) ? 32'(look_lhs.entry) : '0;
                result_next.lhs_status = lk_stat;
            end
            OP_KILL:
            begin
                result_next.op_out     = OP_PASS;
                result_next.lhs_out    = (lk_stat == ST_OK) ? lhs_v : '0;
                result_next.lhs_status = lk_stat;
                used_calc              = used_reg & ~kill_mask;
            end
            OP_NEW_FUNC:
            begin
                map_wr.clear = 1'b1;
            end
            default:
            begin
                result_next.op_out = s1_item_reg.opcode;
            end
        endcase

        // Drop the map writes and the clear unless the word advances
        if (!s1_fire)
        begin
            map_wr.a_en  = 1'b0;
            map_wr.b_en  = 1'b0;
            map_wr.clear = 1'b0;
        end
    end

    assign used_next = s1_fire ? used_calc : used_reg;
    assign snap_next = (s1_fire && s1_item_reg.opcode == OP_CALL)
                       ? SNAP_W'(snap_reg + SNAP_W'(1)) : snap_reg;

    assign s1_valid_next  = item_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    // Control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
            snap_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            snap_reg      <= snap_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_item_reg <= item;
        end
        if (s1_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    `TRA_ASSERT_NEXT(a_kill_becomes_nop, s1_fire && s1_item_reg.opcode == OP_KILL, result.op_out == OP_PASS, "kill did not turn into a nop")
    `TRA_ASSERT_NEXT(a_used_only_freed_by_kill, s1_fire && s1_item_reg.opcode != OP_KILL, (used_reg & $past(used_reg)) == $past(used_reg), "temporary freed outside a kill")
    `TRA_ASSERT_NEXT(a_snap_moves_on_call, !(s1_fire && s1_item_reg.opcode == OP_CALL), $stable(snap_reg), "snapshot count moved without a call")
    `TRA_ASSERT_SAME(a_stall_only_when_full, !item_ready, s1_valid_reg && out_valid_reg && !result_ready, "input stalled with room in the pipeline")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for temp_register_allocator: directed and random IR words.
// Depends on tra_pkg and the allocator RTL; the scoreboard class predicts every result.
`timescale 1ns / 1ps

import tra_pkg::*;

class regalloc_scoreboard;
    logic [NUM_TEMPS-1:0] used_bits;
    logic [TEMP_W-1:0]    map_entry [NUM_VIRTUALS];
    bit                   map_valid [NUM_VIRTUALS];
    logic [SNAP_W-1:0]    snap_count;
    tra_result_t          pending_rewrites [$];
    int                   errors;

    function new();
        used_bits  = '0;
        snap_count = '0;
        errors     = 0;
        foreach (map_valid[i]) begin
            map_valid[i] = 1'b0;
            map_entry[i] = '0;
        end
    endfunction

    // Map a virtual register, taking the lowest free temporary if unmapped
    function logic [31:0] grab_temp(int v, output logic [1:0] st);
        logic [VIRT_W-1:0] vi;
        st = ST_RANGE;
        if (v < 0 || v >= NUM_VIRTUALS)
            return '0;
        vi = VIRT_W'(v);
        st = ST_OK;
        if (map_valid[vi])
            return 32'(map_entry[vi]);
        for (int i = 0; i < NUM_TEMPS; i++) begin
            if (!used_bits[i]) begin
                used_bits[i]  = 1'b1;
                map_entry[vi] = TEMP_W'(i);
                map_valid[vi] = 1'b1;
                return 32'(i);
            end
        end
        st = ST_NO_FREE;
        return '0;
    endfunction

    function logic [31:0] find_temp(int v, output logic [1:0] st);
        logic [VIRT_W-1:0] vi;
        st = ST_RANGE;
        if (v < 0 || v >= NUM_VIRTUALS)
            return '0;
        vi = VIRT_W'(v);
        st = ST_UNMAPPED;
        if (!map_valid[vi])
            return '0;
        st = ST_OK;
        return 32'(map_entry[vi]);
    endfunction

    // Rewrite one instruction word and advance the allocator state
    function tra_result_t rewrite_operands(tra_item_t w);
        tra_result_t e;
        logic [1:0]  st;
        logic [31:0] p;
        int          lv;
        int          rv;
        int          a;
        lv           = w.lhs_in;
        rv           = w.rhs_in;
        e.op_out     = w.opcode;
        e.lhs_out    = w.lhs_in;
        e.lhs_status = ST_OK;
        e.rhs_out    = w.rhs_in;
        e.rhs_status = ST_OK;
        e.used_mask  = '0;
        case (w.opcode)
            OP_DEFINE:
            begin
                e.lhs_out    = grab_temp(lv, st);
                e.lhs_status = st;
            end
            OP_FUNC_ARG:
            begin
                e.rhs_out    = grab_temp(rv, st);
                e.rhs_status = st;
                if (lv < 0 || lv >= NUM_TEMPS) begin
                    e.lhs_status = ST_RANGE;
                    e.lhs_out    = '0;
                end
                else begin
                    a = NUM_TEMPS - 1 - lv;
                    if (used_bits[a]) begin
                        e.lhs_status = ST_NO_FREE;
                        e.lhs_out    = '0;
                    end
                    else begin
                        used_bits[a] = 1'b1;
                        e.lhs_out    = 32'(a);
                        // the rhs temporary index is reused as a map index
                        if (st == ST_OK) begin
                            map_entry[VIRT_W'(e.rhs_out)] = TEMP_W'(a);
                            map_valid[VIRT_W'(e.rhs_out)] = 1'b1;
                        end
                    end
                end
            end
            OP_CALL:
            begin
                e.used_mask  = used_bits;
                e.rhs_out    = 32'(snap_count);
                snap_count   = snap_count + 1'b1;
                e.lhs_out    = grab_temp(lv, st);
                e.lhs_status = st;
            end
            OP_TWO_REGS:
            begin
                e.lhs_out    = grab_temp(lv, st);
                e.lhs_status = st;
                e.rhs_out    = grab_temp(rv, st);
                e.rhs_status = st;
            end
            OP_STORE:
            begin
                e.lhs_out    = find_temp(lv, st);
                e.lhs_status = st;
                e.rhs_out    = grab_temp(rv, st);
                e.rhs_status = st;
            end
            OP_USE:
            begin
                e.lhs_out    = find_temp(lv, st);
                e.lhs_status = st;
            end
            OP_KILL:
            begin
                p            = find_temp(lv, st);
                e.lhs_status = st;
                if (st == ST_OK)
                    used_bits[TEMP_W'(p)] = 1'b0;
                else
                    e.lhs_out = '0;
                e.op_out = OP_PASS;
            end
            OP_NEW_FUNC:
            begin
                foreach (map_valid[i])
                    map_valid[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return e;
    endfunction

    function void note_instruction(tra_item_t w);
        pending_rewrites.push_back(rewrite_operands(w));
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function void check_rewrite(tra_result_t got);
        tra_result_t want;
        if (pending_rewrites.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected, actual %h", $time, got);
            return;
        end
        want = pending_rewrites.pop_front();
        compare("op_out", 32'(want.op_out), 32'(got.op_out));
        compare("lhs_out", want.lhs_out, got.lhs_out);
        compare("lhs_status", 32'(want.lhs_status), 32'(got.lhs_status));
        compare("rhs_out", want.rhs_out, got.rhs_out);
        compare("rhs_status", 32'(want.rhs_status), 32'(got.rhs_status));
        compare("used_mask", 32'(want.used_mask), 32'(got.used_mask));
    endfunction
endclass

module tb;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          TARGET_WORDS   = 1800;
    localparam int          QUIET_FROM     = 1500;
    localparam logic [3:0]  OP_UNKNOWN_LO  = 4'd9;
    localparam logic [3:0]  OP_UNKNOWN_HI  = 4'd15;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    tra_item_t   item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    tra_result_t result;

    regalloc_scoreboard sb = new();

    bit idle_on     = 1'b1;
    int words_sent  = 0;
    int cycles      = 0;
    int stall_left  = 0;
    int live_virts [$];

    temp_register_allocator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Predict on each accepted word, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_valid && item_ready)
                sb.note_instruction(item);
            if (result_valid && result_ready)
                sb.check_rewrite(result);
        end
    end

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    // Present one word, with an optional idle burst first, and hold it until taken
    task automatic send_word(tra_item_t w);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_op(logic [3:0] op, int lhs, int rhs);
        tra_item_t w;
        w.opcode = op;
        w.lhs_in = lhs;
        w.rhs_in = rhs;
        send_word(w);
    endtask

    // Hold the sender until every expected result has come back
    task automatic pause_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rewrites.size() != 0)
            @(posedge clk);
    endtask

    function automatic int fresh_virt();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, NUM_VIRTUALS - 1);
        return $urandom_range(0, 47);
    endfunction

    function automatic int pick_live();
        if (live_virts.size() == 0)
            return fresh_virt();
        return live_virts[$urandom_range(0, live_virts.size() - 1)];
    endfunction

    // Operands that miss the map or the argument range
    function automatic int wild_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return -1;
            2: return NUM_VIRTUALS + $urandom_range(0, 63);
            3: return -int'($urandom_range(2, 10));
            default: return 32'h8000_0000;
        endcase
    endfunction

    task automatic run_directed();
        send_op(OP_NEW_FUNC, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_PASS, -1, 0);
        send_op(OP_DEFINE, 0, -2);
        send_op(OP_DEFINE, NUM_VIRTUALS - 1, 0);
        send_op(OP_DEFINE, NUM_VIRTUALS, 0);
        send_op(OP_DEFINE, 32'h8000_0000, 0);
        send_op(OP_TWO_REGS, 0, 3);
        send_op(OP_STORE, 5, 7);
        send_op(OP_STORE, NUM_VIRTUALS - 1, -10);
        send_op(OP_USE, 3, 32'h7FFF_FFFF);
        send_op(OP_USE, 9, 0);
        send_op(OP_USE, 300, 0);
        // argument registers from the top, a taken one, out of range, failed rhs
        send_op(OP_FUNC_ARG, 0, 20);
        send_op(OP_FUNC_ARG, 0, 21);
        send_op(OP_FUNC_ARG, NUM_TEMPS, 22);
        send_op(OP_FUNC_ARG, -1, 999);
        send_op(OP_FUNC_ARG, 1, -3);
        send_op(OP_CALL, 30, 12345);
        send_op(OP_KILL, 0, -1);
        send_op(OP_KILL, 77, 0);
        send_op(OP_KILL, 1000, 0);
        send_op(OP_UNKNOWN_LO, $urandom, $urandom);
        send_op(OP_UNKNOWN_HI, -1, -1);
        send_op(OP_USE, 0, 0);
        send_op(OP_CALL, 31, 0);
    endtask

    // One function body: well-formed allocate/use/kill traffic plus some noise
    task automatic run_body(int n_ops);
        int         r;
        int         idx;
        int         v;
        logic [3:0] op;
        for (int k = 0; k < n_ops; k++) begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
                v = fresh_virt();
                live_virts.push_back(v);
                send_op(OP_DEFINE, v, $urandom);
            end
            else if (r < 30) begin
                v = fresh_virt();
                send_op(OP_TWO_REGS, pick_live(), v);
                live_virts.push_back(v);
            end
            else if (r < 40) begin
                v = fresh_virt();
                send_op(OP_STORE, pick_live(), v);
                live_virts.push_back(v);
            end
            else if (r < 52) begin
                send_op(OP_USE, pick_live(), $urandom);
            end
            else if (r < 66) begin
                if (live_virts.size() == 0) begin
                    v = fresh_virt();
                end
                else begin
                    idx = $urandom_range(0, live_virts.size() - 1);
                    v   = live_virts[idx];
                    live_virts.delete(idx);
                end
                send_op(OP_KILL, v, $urandom);
            end
            else if (r < 72) begin
                v = fresh_virt();
                live_virts.push_back(v);
                send_op(OP_CALL, v, $urandom);
            end
            else if (r < 78) begin
                v = fresh_virt();
                live_virts.push_back(v);
                if ($urandom_range(0, 7) == 0)
                    send_op(OP_FUNC_ARG, wild_value(), v);
                else
                    send_op(OP_FUNC_ARG, $urandom_range(0, NUM_TEMPS - 1), v);
            end
            else if (r < 86) begin
                if ($urandom_range(0, 7) == 0)
                    op = OP_PASS;
                else
                    op = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
                send_op(op, $urandom, $urandom);
            end
            else begin
                send_op(4'($urandom_range(OP_DEFINE, OP_KILL)), wild_value(), wild_value());
            end
        end
        // Free what is live, mostly, and some argument-register holders
        while (live_virts.size() > 0) begin
            v = live_virts.pop_front();
            if ($urandom_range(0, 9) != 0)
                send_op(OP_KILL, v, $urandom);
        end
        for (v = 0; v < NUM_TEMPS; v++) begin
            if ($urandom_range(0, 2) == 0)
                send_op(OP_KILL, v, $urandom);
        end
        send_op(OP_NEW_FUNC, $urandom, $urandom);
    endtask

    initial
    begin
        int body_no;
        body_no = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        pause_drained();
        while (words_sent < TARGET_WORDS) begin
            idle_on = (words_sent < QUIET_FROM) && (body_no % 4 != 3);
            run_body($urandom_range(20, 60));
            if (body_no % 6 == 5)
                pause_drained();
            body_no++;
        end
        pause_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rewrites.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
